FILE: rtl/energy_voice_activity_segmenter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the energy voice activity segmenter
// Shorthand for the concurrent checks that close the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EVAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evas: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EVAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evas: next-cycle check failed");

`endif

FILE: rtl/evas_pkg.sv
// ----------------------------------------------------------------------------
// Energy voice activity segmenter package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package evas_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int SQUARE_W        = 31;
    localparam int ENERGY_W        = 42;
    localparam int THRESH_W        = 31;
    localparam int CFG_LEN_W       = 24;
    localparam int CHUNK_SAMPLES_W = 12;
    localparam int SEG_OUT_W       = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENERGY_THRESHOLD = 2'd0,
        REG_HANGOVER_SAMPLES = 2'd1,
        REG_MIN_SPEECH       = 2'd2,
        REG_MAX_SPEECH       = 2'd3
    } t_cfg_reg;

    localparam logic [THRESH_W-1:0]  RST_ENERGY_THRESHOLD = 31'd10737418;
    localparam logic [CFG_LEN_W-1:0] RST_HANGOVER_SAMPLES = 24'd12800;
    localparam logic [CFG_LEN_W-1:0] RST_MIN_SPEECH       = 24'd4800;
    localparam logic [CFG_LEN_W-1:0] RST_MAX_SPEECH       = 24'd480000;

    typedef struct packed {
        logic [THRESH_W-1:0]  energy_threshold;
        logic [CFG_LEN_W-1:0] hangover_samples;
        logic [CFG_LEN_W-1:0] min_speech_samples;
        logic [CFG_LEN_W-1:0] max_speech_samples;
    } t_cfg;

    typedef struct packed {
        logic                       chunk_loud;
        logic [ENERGY_W-1:0]        chunk_energy;
        logic [CHUNK_SAMPLES_W-1:0] chunk_samples;
        logic                       speech_started;
        logic                       speech_ended;
        logic                       segment_dropped;
        logic [SEG_OUT_W-1:0]       segment_samples;
        logic                       speaking;
    } t_result;

endpackage

FILE: rtl/evas_if.sv
// ----------------------------------------------------------------------------
// Energy voice activity segmenter channel interfaces
// Sample input, per-chunk result output and configuration write channels.
// ----------------------------------------------------------------------------
interface evas_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [evas_pkg::SAMPLE_W-1:0] sample;
    logic                                chunk_end;

    modport source (output valid, output sample, output chunk_end, input ready);
    modport sink   (input valid, input sample, input chunk_end, output ready);
endinterface

interface evas_result_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  chunk_loud;
    logic [evas_pkg::ENERGY_W-1:0]         chunk_energy;
    logic [evas_pkg::CHUNK_SAMPLES_W-1:0]  chunk_samples;
    logic                                  speech_started;
    logic                                  speech_ended;
    logic                                  segment_dropped;
    logic [evas_pkg::SEG_OUT_W-1:0]        segment_samples;
    logic                                  speaking;

    modport source (
        output valid, output chunk_loud, output chunk_energy, output chunk_samples,
        output speech_started, output speech_ended, output segment_dropped,
        output segment_samples, output speaking, input ready
    );
    modport sink (
        input valid, input chunk_loud, input chunk_energy, input chunk_samples,
        input speech_started, input speech_ended, input segment_dropped,
        input segment_samples, input speaking, output ready
    );
endinterface

interface evas_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [evas_pkg::CFG_IDX_W-1:0]   index;
    logic [evas_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/energy_voice_activity_segmenter.sv
// ----------------------------------------------------------------------------
// Energy voice activity segmenter
// Chunk energy test, speech segment tracking with hangover and length limits.
// ----------------------------------------------------------------------------
// The block takes one audio sample per clock cycle while results are
// taken, and returns one result transaction for every sample that carries
// chunk_end, and none for the others. A sample passes through five
// registered stages: input register, squarer, chunk accumulator, threshold
// multiplier and the segment decision that feeds the output register. The
// sustained rate is one sample per cycle while results are taken, chunks of
// a single sample included; it is set by the 42-bit energy accumulator and
// by the segment state (active flag, length, hangover), each of which
// updates once per cycle. Every stage has its own valid bit, so the block
// keeps accepting samples while a result waits to be taken, until the
// stages in front of the waiting result are full. There is no clearing
// pass after reset.
// Configuration writes are accepted in every cycle and must only be issued
// while no chunk result is outstanding.
`include "energy_voice_activity_segmenter_defines.svh"

module energy_voice_activity_segmenter #(
    parameter int MAX_CHUNK   = 2048,
    parameter int LENGTH_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    evas_sample_if.sink   i_sample_ch,
    evas_result_if.source o_result_ch,
    evas_cfg_if.sink      i_cfg_ch
);

    // The chunk counter must be able to hold MAX_CHUNK itself.
    localparam int CNT_W   = $clog2(MAX_CHUNK + 1);
    localparam int EW      = evas_pkg::ENERGY_W;
    localparam int LW      = evas_pkg::CFG_LEN_W;
    // Threshold times sample count, the right-hand side of the loudness test.
    localparam int PROD_W  = evas_pkg::THRESH_W + CNT_W;
    localparam int CMP_W   = (PROD_W > EW) ? PROD_W : EW;
    // Saturating segment length sum needs one carry bit over its operands.
    localparam int SUM_W   = ((LENGTH_BITS > CNT_W) ? LENGTH_BITS : CNT_W) + 1;
    localparam int HANG_W  = (LW > CNT_W) ? LW : CNT_W;
    localparam int MAXC_W  = (LENGTH_BITS > LW) ? LENGTH_BITS : LW;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Configuration registers.
    evas_pkg::t_cfg            r_cfg;

    // Finished chunk handed over by the front end.
    logic                      front_valid;
    logic                      front_ready;
    logic [EW-1:0]             front_energy;
    logic [CNT_W-1:0]          front_count;

    // Product stage.
    logic                      r_d_v;
    logic [EW-1:0]             r_d_energy;
    logic [CNT_W-1:0]          r_d_count;
    logic [PROD_W-1:0]         r_d_prod;

    // Segment state.
    logic                      r_active;
    logic [LENGTH_BITS-1:0]    r_seg_len;
    logic [LW-1:0]             r_hang;

    // Output register.
    logic                      r_e_v;
    evas_pkg::t_result         r_res;

    logic                      e_load;
    logic                      d_load;
    logic                      d_go;
    logic [PROD_W-1:0]         n_prod;
    logic                      loud;
    logic                      start;
    logic                      active_eff;
    logic [LENGTH_BITS-1:0]    seg_base;
    logic [SUM_W-1:0]          seg_sum;
    logic [LENGTH_BITS-1:0]    n_seg_len;
    logic [HANG_W-1:0]         hang_diff;
    logic [LW-1:0]             hang_dec;
    logic [LW-1:0]             n_hang;
    logic                      finish;
    logic                      dropped;
    logic [LENGTH_BITS-1:0]    seg_out;
    evas_pkg::t_result         n_res;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; the stored value is
    // trimmed to the width of the register it lands in.
    // ------------------------------------------------------------------
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_threshold   <= evas_pkg::RST_ENERGY_THRESHOLD;
            r_cfg.hangover_samples   <= evas_pkg::RST_HANGOVER_SAMPLES;
            r_cfg.min_speech_samples <= evas_pkg::RST_MIN_SPEECH;
            r_cfg.max_speech_samples <= evas_pkg::RST_MAX_SPEECH;
        end else if (i_cfg_ch.valid) begin
            unique case (evas_pkg::t_cfg_reg'(i_cfg_ch.index))
                evas_pkg::REG_ENERGY_THRESHOLD: begin
                    r_cfg.energy_threshold <= i_cfg_ch.data[evas_pkg::THRESH_W-1:0];
                end
                evas_pkg::REG_HANGOVER_SAMPLES: begin
                    r_cfg.hangover_samples <= i_cfg_ch.data[LW-1:0];
                end
                evas_pkg::REG_MIN_SPEECH: begin
                    r_cfg.min_speech_samples <= i_cfg_ch.data[LW-1:0];
                end
                evas_pkg::REG_MAX_SPEECH: begin
                    r_cfg.max_speech_samples <= i_cfg_ch.data[LW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: input register, squarer and chunk accumulator.
    // ------------------------------------------------------------------
    evas_energy_front #(
        .MAX_CHUNK (MAX_CHUNK),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (i_sample_ch),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_energy    (front_energy),
        .o_count     (front_count)
    );

    // ------------------------------------------------------------------
    // Stage flow. Each stage moves on when the one after it is empty or
    // is itself moving on in the same cycle.
    // ------------------------------------------------------------------
    assign e_load      = !r_e_v || o_result_ch.ready;
    assign d_go        = r_d_v && e_load;
    assign d_load      = !r_d_v || e_load;
    assign front_ready = d_load;

    // The threshold is scaled by the saturated sample count of the chunk,
    // which keeps the comparison in squared-sample units and needs no
    // division by the count.
    assign n_prod = PROD_W'(r_cfg.energy_threshold) * PROD_W'(front_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (d_load) begin
            r_d_v <= front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_load && front_valid) begin
            r_d_energy <= front_energy;
            r_d_count  <= front_count;
            r_d_prod   <= n_prod;
        end
    end

    // ------------------------------------------------------------------
    // Segment decision.
    // ------------------------------------------------------------------
    always_comb begin
        loud       = CMP_W'(r_d_energy) > CMP_W'(r_d_prod);
        // A loud chunk while no segment is open starts a fresh one.
        start      = loud && !r_active;
        active_eff = r_active || loud;
        seg_base   = start ? '0 : r_seg_len;

        // Every chunk of an open segment lengthens it, saturating at the
        // largest value the length register holds.
        seg_sum    = SUM_W'(seg_base) + SUM_W'(r_d_count);
        n_seg_len  = (seg_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : seg_sum[LENGTH_BITS-1:0];

        // Loud chunks reload the hangover, quiet ones count it down to zero.
        hang_diff  = HANG_W'(r_hang) - HANG_W'(r_d_count);
        hang_dec   = (HANG_W'(r_hang) > HANG_W'(r_d_count)) ? hang_diff[LW-1:0] : '0;
        n_hang     = loud ? r_cfg.hangover_samples : hang_dec;

        // The segment closes when the hangover runs out or it reaches the
        // maximum length; a short one is discarded rather than reported.
        finish     = active_eff && ((n_hang == '0) ||
                     (MAXC_W'(n_seg_len) >= MAXC_W'(r_cfg.max_speech_samples)));
        dropped    = finish &&
                     (MAXC_W'(n_seg_len) < MAXC_W'(r_cfg.min_speech_samples));
        seg_out    = active_eff ? n_seg_len : r_seg_len;

        n_res.chunk_loud      = loud;
        n_res.chunk_energy    = r_d_energy;
        n_res.chunk_samples   = evas_pkg::CHUNK_SAMPLES_W'(r_d_count);
        n_res.speech_started  = start;
        n_res.speech_ended    = finish && !dropped;
        n_res.segment_dropped = dropped;
        n_res.segment_samples = evas_pkg::SEG_OUT_W'(seg_out);
        n_res.speaking        = active_eff && !finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_seg_len <= '0;
            r_hang    <= '0;
            r_e_v     <= 1'b0;
        end else begin
            if (e_load) begin
                r_e_v <= r_d_v;
            end
            if (d_go) begin
                if (finish) begin
                    r_active  <= 1'b0;
                    r_seg_len <= '0;
                    r_hang    <= '0;
                end else if (active_eff) begin
                    r_active  <= 1'b1;
                    r_seg_len <= n_seg_len;
                    r_hang    <= n_hang;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_go) begin
            r_res <= n_res;
        end
    end

    assign o_result_ch.valid           = r_e_v;
    assign o_result_ch.chunk_loud      = r_res.chunk_loud;
    assign o_result_ch.chunk_energy    = r_res.chunk_energy;
    assign o_result_ch.chunk_samples   = r_res.chunk_samples;
    assign o_result_ch.speech_started  = r_res.speech_started;
    assign o_result_ch.speech_ended    = r_res.speech_ended;
    assign o_result_ch.segment_dropped = r_res.segment_dropped;
    assign o_result_ch.segment_samples = r_res.segment_samples;
    assign o_result_ch.speaking        = r_res.speaking;

    `EVAS_ASSERT_SAME(a_closed_not_speaking, i_clk, i_rst_n,
                      r_e_v && (r_res.speech_ended || r_res.segment_dropped), !r_res.speaking)
    `EVAS_ASSERT_SAME(a_end_or_drop, i_clk, i_rst_n, r_e_v,
                      !(r_res.speech_ended && r_res.segment_dropped))
    `EVAS_ASSERT_SAME(a_start_needs_loud, i_clk, i_rst_n, r_e_v && r_res.speech_started,
                      r_res.chunk_loud)
    `EVAS_ASSERT_SAME(a_idle_state_clear, i_clk, i_rst_n, !r_active,
                      (r_seg_len == '0) && (r_hang == '0))

endmodule

FILE: rtl/evas_energy_front.sv
// ----------------------------------------------------------------------------
// Energy voice activity segmenter chunk energy front end
// Registers samples, squares them and accumulates energy and count per chunk.
// ----------------------------------------------------------------------------
`include "energy_voice_activity_segmenter_defines.svh"

module evas_energy_front #(
    parameter int MAX_CHUNK = 2048,
    parameter int CNT_W     = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    evas_sample_if.sink                   i_sample_ch,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [evas_pkg::ENERGY_W-1:0] o_energy,
    output logic [CNT_W-1:0]              o_count
);

    localparam int EW = evas_pkg::ENERGY_W;

    // Input stage.
    logic                                 r_a_v;
    logic signed [evas_pkg::SAMPLE_W-1:0] r_a_sample;
    logic                                 r_a_end;
    // Square stage.
    logic                                 r_b_v;
    logic [evas_pkg::SQUARE_W-1:0]        r_b_sq;
    logic                                 r_b_end;
    // Running chunk accumulators.
    logic [EW-1:0]                        r_acc;
    logic [CNT_W-1:0]                     r_cnt;
    // Finished chunk stage.
    logic                                 r_c_v;
    logic [EW-1:0]                        r_c_energy;
    logic [CNT_W-1:0]                     r_c_count;

    logic                                 c_load;
    logic                                 b_go;
    logic                                 b_load;
    logic                                 a_go;
    logic                                 a_load;
    logic                                 accept;
    logic signed [31:0]                   square_s;
    logic [EW:0]                          acc_sum;
    logic [EW-1:0]                        n_acc;
    logic [CNT_W-1:0]                     n_cnt;

    // A sample that does not close a chunk is absorbed into the accumulators
    // and never waits for the finished chunk stage.
    assign c_load = !r_c_v || i_ready;
    assign b_go   = r_b_v && (!r_b_end || c_load);
    assign b_load = !r_b_v || b_go;
    assign a_go   = r_a_v && b_load;
    assign a_load = !r_a_v || a_go;
    assign accept = i_sample_ch.valid && a_load;

    assign i_sample_ch.ready = a_load;

    assign square_s = r_a_sample * r_a_sample;
    assign acc_sum  = {1'b0, r_acc} + (EW + 1)'(r_b_sq);
    assign n_acc    = acc_sum[EW] ? {EW{1'b1}} : acc_sum[EW-1:0];
    assign n_cnt    = (r_cnt < CNT_W'(MAX_CHUNK)) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            if (a_load) begin
                r_a_v <= accept;
            end
            if (b_load) begin
                r_b_v <= a_go;
            end
            if (c_load) begin
                r_c_v <= b_go && r_b_end;
            end
            if (b_go) begin
                if (r_b_end) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_sample <= i_sample_ch.sample;
            r_a_end    <= i_sample_ch.chunk_end;
        end
        if (a_go) begin
            r_b_sq  <= square_s[evas_pkg::SQUARE_W-1:0];
            r_b_end <= r_a_end;
        end
        if (b_go && r_b_end) begin
            r_c_energy <= n_acc;
            r_c_count  <= n_cnt;
        end
    end

    assign o_valid  = r_c_v;
    assign o_energy = r_c_energy;
    assign o_count  = r_c_count;

    `EVAS_ASSERT_SAME(a_cnt_bounded, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_CHUNK))
    `EVAS_ASSERT_SAME(a_chunk_not_empty, i_clk, i_rst_n, r_c_v, r_c_count != '0)
    `EVAS_ASSERT_NEXT(a_chunk_held, i_clk, i_rst_n, r_c_v && !i_ready,
                      r_c_v && $stable(r_c_energy) && $stable(r_c_count))

endmodule

FILE: test/energy_voice_activity_segmenter_tb.sv
// ----------------------------------------------------------------------------
// Energy voice activity segmenter testbench
// Sends chunked audio samples and register writes through the channel
// interfaces, with random idle gaps on both sides. A small tracking class
// predicts the verdict of every chunk, and each result transaction is
// compared with that prediction field by field.
// ----------------------------------------------------------------------------
module energy_voice_activity_segmenter_tb;

    localparam int MAX_CHUNK     = 2048;
    localparam int LENGTH_BITS   = 24;
    localparam int RAND_ITEMS    = 600;
    localparam int RAND_PHASES   = 8;
    // Cycles without any transaction before the run is declared hung.
    localparam int IDLE_LIMIT    = 4000;
    // The block has five register stages, which the settling wait covers.
    localparam int SETTLE_CYCLES = 10;
    // Upper write data bits that the length registers do not keep.
    localparam int PAD_W         = evas_pkg::CFG_DATA_W - evas_pkg::CFG_LEN_W;

    localparam longint unsigned ENERGY_CAP = (64'd1 << evas_pkg::ENERGY_W) - 1;
    localparam longint unsigned LENGTH_CAP = (64'd1 << LENGTH_BITS) - 1;

    // Flavours of chunk content, chosen so that loud and quiet chunks fall
    // clearly on either side of the moderate thresholds used in most phases.
    typedef enum int {
        CK_SILENT,
        CK_QUIET,
        CK_LOUD,
        CK_NOISE,
        CK_PEAK
    } t_chunk_kind;

    // ------------------------------------------------------------------------
    // Chunk verdict tracker: keeps its own copy of the registers and of the
    // segment state, works out the verdict of every chunk as its last sample
    // is accepted, and holds the verdicts until the block delivers them.
    // ------------------------------------------------------------------------
    class segment_tracker;
        longint unsigned thr;
        longint unsigned hang_cfg;
        longint unsigned min_len;
        longint unsigned max_len;

        bit              in_speech;
        longint unsigned seg_len;
        longint unsigned energy_acc;
        longint unsigned chunk_len;
        longint unsigned hang_left;

        evas_pkg::t_result pending_verdicts[$];
        int unsigned       faults;

        function new();
            thr        = evas_pkg::RST_ENERGY_THRESHOLD;
            hang_cfg   = evas_pkg::RST_HANGOVER_SAMPLES;
            min_len    = evas_pkg::RST_MIN_SPEECH;
            max_len    = evas_pkg::RST_MAX_SPEECH;
            in_speech  = 1'b0;
            seg_len    = 0;
            energy_acc = 0;
            chunk_len  = 0;
            hang_left  = 0;
            faults     = 0;
        endfunction

        // Only the low bits of the write data that fit the register are kept.
        function void write_reg(evas_pkg::t_cfg_reg idx,
                                logic [evas_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                evas_pkg::REG_ENERGY_THRESHOLD: thr      = val[evas_pkg::THRESH_W-1:0];
                evas_pkg::REG_HANGOVER_SAMPLES: hang_cfg = val[evas_pkg::CFG_LEN_W-1:0];
                evas_pkg::REG_MIN_SPEECH:       min_len  = val[evas_pkg::CFG_LEN_W-1:0];
                evas_pkg::REG_MAX_SPEECH:       max_len  = val[evas_pkg::CFG_LEN_W-1:0];
            endcase
        endfunction

        function void absorb_sample(logic signed [evas_pkg::SAMPLE_W-1:0] s, logic closes);
            longint            sv;
            longint unsigned   sq;
            longint unsigned   n;
            longint unsigned   energy;
            bit                loud;
            bit                finish;
            evas_pkg::t_result v;
            sv = s;
            sq = sv * sv;
            energy_acc = (ENERGY_CAP - energy_acc < sq) ? ENERGY_CAP : energy_acc + sq;
            if (chunk_len < MAX_CHUNK) chunk_len++;
            if (!closes) return;

            n          = chunk_len;
            energy     = energy_acc;
            chunk_len  = 0;
            energy_acc = 0;
            v          = '0;
            finish     = 1'b0;

            // Mean-square test without a division: energy against threshold * count.
            loud = energy > thr * n;
            if (loud && !in_speech) begin
                in_speech        = 1'b1;
                seg_len          = 0;
                v.speech_started = 1'b1;
            end
            if (in_speech) begin
                seg_len = (LENGTH_CAP - seg_len < n) ? LENGTH_CAP : seg_len + n;
                if (loud) begin
                    hang_left = hang_cfg;
                end else begin
                    hang_left = (hang_left > n) ? hang_left - n : 0;
                end
                finish = (hang_left == 0) || (seg_len >= max_len);
            end
            v.segment_samples = seg_len[evas_pkg::SEG_OUT_W-1:0];
            if (finish) begin
                if (seg_len < min_len) begin
                    v.segment_dropped = 1'b1;
                end else begin
                    v.speech_ended = 1'b1;
                end
                in_speech = 1'b0;
                seg_len   = 0;
                hang_left = 0;
            end
            v.chunk_loud    = loud;
            v.chunk_energy  = energy[evas_pkg::ENERGY_W-1:0];
            v.chunk_samples = n[evas_pkg::CHUNK_SAMPLES_W-1:0];
            v.speaking      = in_speech;
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            faults++;
            if (faults <= 10)
                $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got) flag(what, want, got);
        endfunction

        function void check_verdict(evas_pkg::t_result got);
            evas_pkg::t_result want;
            if (pending_verdicts.size() == 0) begin
                flag("unexpected result, chunk_samples", 0, got.chunk_samples);
                return;
            end
            want = pending_verdicts.pop_front();
            compare("chunk_loud",      want.chunk_loud,      got.chunk_loud);
            compare("chunk_energy",    want.chunk_energy,    got.chunk_energy);
            compare("chunk_samples",   want.chunk_samples,   got.chunk_samples);
            compare("speech_started",  want.speech_started,  got.speech_started);
            compare("speech_ended",    want.speech_ended,    got.speech_ended);
            compare("segment_dropped", want.segment_dropped, got.segment_dropped);
            compare("segment_samples", want.segment_samples, got.segment_samples);
            compare("speaking",        want.speaking,        got.speaking);
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    // When set, neither side inserts idle cycles, giving back-to-back stretches.
    bit             calm;
    int unsigned    idle_cycles;
    int             stall_left = 0;
    segment_tracker tracker = new();

    evas_sample_if sample_ch ();
    evas_result_if result_ch ();
    evas_cfg_if    cfg_ch ();

    energy_voice_activity_segmenter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_ch    (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle gap length: usually none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [evas_pkg::SAMPLE_W-1:0] pick_sample(t_chunk_kind kind);
        logic signed [evas_pkg::SAMPLE_W-1:0] mag;
        case (kind)
            CK_SILENT: return '0;
            CK_QUIET:  return evas_pkg::SAMPLE_W'($signed($urandom_range(0, 600)) - 300);
            CK_LOUD: begin
                mag = evas_pkg::SAMPLE_W'($urandom_range(2000, 32767));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            CK_PEAK:   return 16'sh8000;
            default:   return evas_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // The result side stalls at random. Ready is only ever changed on the
    // falling edge, so the block sees a settled value at every rising edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else begin
            result_ch.ready <= 1'b1;
            stall_left      <= pick_gap();
        end
    end

    // Result monitor and watchdog. Everything is sampled at the rising edge,
    // where the values seen are those the block itself acts upon.
    always @(posedge i_clk) begin
        evas_pkg::t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.chunk_loud      = result_ch.chunk_loud;
            got.chunk_energy    = result_ch.chunk_energy;
            got.chunk_samples   = result_ch.chunk_samples;
            got.speech_started  = result_ch.speech_started;
            got.speech_ended    = result_ch.speech_ended;
            got.segment_dropped = result_ch.segment_dropped;
            got.segment_samples = result_ch.segment_samples;
            got.speaking        = result_ch.speaking;
            tracker.check_verdict(got);
        end
        if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // All driving tasks are entered and left on a falling edge. Valid is left
    // high on return, so that back-to-back transactions never lower and raise
    // it within the same time step; only a gap, drain or configure lowers it.
    task automatic send_sample(logic signed [evas_pkg::SAMPLE_W-1:0] s, logic closes);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid  <= 1'b0;
            // The payload wanders while valid is low; the block must ignore it.
            sample_ch.sample <= evas_pkg::SAMPLE_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample    <= s;
        sample_ch.chunk_end <= closes;
        do @(posedge i_clk); while (!sample_ch.ready);
        tracker.absorb_sample(s, closes);
        @(negedge i_clk);
    endtask

    task automatic send_chunk(t_chunk_kind kind, int len);
        for (int k = 0; k < len; k++) send_sample(pick_sample(kind), k == len - 1);
    endtask

    // Holds the sender back until every chunk verdict has arrived, then lets
    // the pipeline settle so that nothing is still in flight.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(evas_pkg::t_cfg_reg idx, logic [evas_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic configure(logic [evas_pkg::CFG_DATA_W-1:0] thr,
                             logic [evas_pkg::CFG_DATA_W-1:0] hang,
                             logic [evas_pkg::CFG_DATA_W-1:0] lo,
                             logic [evas_pkg::CFG_DATA_W-1:0] hi);
        drain();
        write_reg(evas_pkg::REG_ENERGY_THRESHOLD, thr);
        write_reg(evas_pkg::REG_HANGOVER_SAMPLES, hang);
        write_reg(evas_pkg::REG_MIN_SPEECH, lo);
        write_reg(evas_pkg::REG_MAX_SPEECH, hi);
        cfg_ch.valid <= 1'b0;
    endtask

    // A random register setting per phase, the extremes included. The unused
    // upper data bits are filled at random to show that they are discarded.
    task automatic random_settings();
        logic [evas_pkg::CFG_DATA_W-1:0] thr;
        logic [evas_pkg::CFG_DATA_W-1:0] hang;
        logic [evas_pkg::CFG_DATA_W-1:0] lo;
        logic [evas_pkg::CFG_DATA_W-1:0] hi;
        case ($urandom_range(0, 9))
            0:       thr = '0;
            1:       thr = '1;
            2:       thr = $urandom;
            default: thr = $urandom_range(50_000, 3_000_000);
        endcase
        case ($urandom_range(0, 7))
            0:       hang = '0;
            1:       hang = '1;
            default: hang = $urandom_range(1, 200);
        endcase
        case ($urandom_range(0, 7))
            0:       lo = '0;
            1:       lo = '1;
            default: lo = $urandom_range(1, 150);
        endcase
        case ($urandom_range(0, 9))
            0:       hi = '0;
            1:       hi = '1;
            2:       hi = 1;
            default: hi = $urandom_range(20, 600);
        endcase
        thr[evas_pkg::CFG_DATA_W-1]                      = 1'($urandom_range(0, 1));
        hang[evas_pkg::CFG_DATA_W-1:evas_pkg::CFG_LEN_W] = PAD_W'($urandom);
        lo[evas_pkg::CFG_DATA_W-1:evas_pkg::CFG_LEN_W]   = PAD_W'($urandom);
        hi[evas_pkg::CFG_DATA_W-1:evas_pkg::CFG_LEN_W]   = PAD_W'($urandom);
        configure(thr, hang, lo, hi);
    endtask

    initial begin
        int          roll;
        int          len;
        int          phase_items;
        t_chunk_kind kind;

        // Every input is known from time zero.
        i_rst_n             = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample    = '0;
        sample_ch.chunk_end = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = evas_pkg::REG_ENERGY_THRESHOLD;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        calm                = 1'b0;
        idle_cycles         = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the reset settings. A silent chunk is never
        // loud; the two single-sample chunks at full scale open a segment.
        send_chunk(CK_SILENT, 3);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_chunk(CK_QUIET, 5);
        // A chunk at full negative scale just longer than the largest count
        // saturates the sample count.
        send_chunk(CK_PEAK, MAX_CHUNK + 2);

        // Zero threshold and zero hangover: the first loud chunk closes the
        // open segment, the next one starts and ends a segment on its own.
        // A silent chunk stays quiet even against a zero threshold.
        configure('0, '0, '0, '1);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b1);
        send_chunk(CK_SILENT, 2);

        // Zero maximum with the largest minimum: every segment ends on the
        // chunk that started it and is dropped as too short.
        configure(32'd1_000_000, '1, '1, '0);
        send_chunk(CK_LOUD, 3);
        send_chunk(CK_QUIET, 4);
        send_chunk(CK_LOUD, 1);

        // Small limits: one segment ends on hangover, another on its maximum.
        configure(32'd1_000_000, 32'd10, 32'd5, 32'd30);
        send_chunk(CK_LOUD, 4);
        send_chunk(CK_QUIET, 4);
        send_chunk(CK_QUIET, 8);
        send_chunk(CK_LOUD, 20);
        send_chunk(CK_LOUD, 20);

        // Random part: a new register setting per phase, some phases without
        // any idling, and now and then a pause until every verdict is back.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_settings();
            calm        = (ph % 4 == 3);
            phase_items = 0;
            while (phase_items < RAND_ITEMS / RAND_PHASES) begin
                roll = $urandom_range(0, 99);
                if (roll < 35)      kind = CK_LOUD;
                else if (roll < 70) kind = CK_QUIET;
                else if (roll < 80) kind = CK_SILENT;
                else if (roll < 95) kind = CK_NOISE;
                else                kind = CK_PEAK;
                roll = $urandom_range(0, 99);
                if (roll < 85)      len = $urandom_range(1, 40);
                else                len = $urandom_range(41, 150);
                send_chunk(kind, len);
                phase_items += len;
                if ($urandom_range(0, 29) == 0) drain();
            end
        end
        calm = 1'b0;

        drain();
        if (tracker.faults == 0 && tracker.pending_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
